>>> hw/rtl/see_pkg.sv
// Shared types and constants of the sprite evaluation engine.
package see_pkg;

    localparam int OAM_SPRITES    = 64;
    localparam int LINE_SLOTS_DEF = 8;
    localparam int OAM_ADDR_W     = 8;
    localparam int DOT_W          = 9;
    localparam int IN_TDATA_W     = 40;
    localparam int OUT_TDATA_W    = 24;

    localparam logic [8:0] CLEAR_LAST_DOT = 9'd64;
    localparam logic [8:0] RESTART_DOT    = 9'd65;
    localparam logic [8:0] LAST_DOT       = 9'd256;
    localparam logic [7:0] FILL_BYTE      = 8'hFF;
    localparam logic [7:0] SHORT_HEIGHT   = 8'd8;
    localparam logic [7:0] TALL_HEIGHT    = 8'd16;
    localparam logic [1:0] OVF_EXTRA      = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RANGE    = 3'd1,
        PH_COPY     = 3'd2,
        PH_OVF_EVAL = 3'd3,
        PH_OVF_COPY = 3'd4
    } phase_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic {
        CFG_TALL_SPRITES = 1'b0,
        CFG_OAM_BASE     = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic       tall_sprites;
        logic [7:0] oam_base;
    } cfg_t;

    typedef struct packed {
        logic       eval_done;
        logic [3:0] slot_count;
        logic       sprite_zero_found;
        logic       overflow_set;
        logic [7:0] sec_data;
        logic [4:0] sec_index;
        logic       sec_write;
    } result_t;

endpackage

>>> hw/rtl/sprite_evaluation_engine.sv
// Sprite evaluation engine top level: stream ports, config registers, submodules.
//
// Evaluates sprites for one scanline, one dot per item. An input item is either a
// load (tuser = 0) that writes one byte of the 256-byte primary OAM, or a dot tick
// (tuser = 1) carrying dot 1..256 and the scanline. Each tick gives exactly one
// result item; loads give none. Dots 1-64 report the clear of secondary OAM to 0xFF,
// dot 65 restarts the search, odd dots read primary OAM at
// (oam_base + sprite*4 + byte) mod 256, and even dots run one search step: range
// check, three-byte copy, overflow scan with its skewed byte increment, or idle.
// Secondary OAM writes are reported on the result channel, not stored here.
// Rate: one item per clock while s_tready is high. A tick's result shows on m_tvalid
// in the cycle after it is accepted. Primary OAM is a single-port-read memory whose
// registered read data serves as the evaluation latch: an odd dot issues the read
// and the following even dot, in the very next cycle or later, uses it. A two-entry
// result buffer decouples the sides; s_tready drops only when both entries hold
// items not yet taken. No clearing pass after reset: primary OAM is undefined until
// loaded. Configuration writes are taken every cycle (cfg_ready is always high) and
// must be issued while the engine is idle.
module sprite_evaluation_engine #(
    parameter int LINE_SLOTS = see_pkg::LINE_SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input item channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: oam_index[7:0], oam_byte[15:8], dot[24:16], scanline[32:25], zero[39:33]
    input  logic [see_pkg::IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: op (0 load, 1 dot tick)
    input  logic                            s_tuser,
    // Result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: sec_write[0], sec_index[5:1], sec_data[13:6], overflow_set[14],
    //          sprite_zero_found[15], slot_count[19:16], eval_done[20], zero[23:21]
    output logic [see_pkg::OUT_TDATA_W-1:0] m_tdata,
    // Configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [7:0]                      cfg_data
);
    import see_pkg::*;

    logic       tall_sprites_reg;
    logic [7:0] oam_base_reg;
    cfg_t       cfg;

    logic       s_fire;
    logic       tick_fire;
    logic       load_fire;

    logic [7:0] in_oam_index;
    logic [7:0] in_oam_byte;
    logic [8:0] in_dot;
    logic [7:0] in_scanline;

    logic       rd_en;
    logic [7:0] rd_addr;
    logic [7:0] latch_data;
    result_t    result;
    result_t    out_result;

    // Unpack the input item.
    assign in_oam_index = s_tdata[7:0];
    assign in_oam_byte  = s_tdata[15:8];
    assign in_dot       = s_tdata[24:16];
    assign in_scanline  = s_tdata[32:25];

    assign s_fire    = s_tvalid && s_tready;
    assign tick_fire = s_fire && (s_tuser == OP_TICK);
    assign load_fire = s_fire && (s_tuser == OP_LOAD);

    // Configuration registers: accept every cycle; both indexes map to a register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tall_sprites_reg <= 1'b0;
            oam_base_reg     <= 8'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TALL_SPRITES: tall_sprites_reg <= cfg_data[0];
                CFG_OAM_BASE:     oam_base_reg     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg.tall_sprites = tall_sprites_reg;
    assign cfg.oam_base     = oam_base_reg;

    // Primary OAM: loads write, odd dots read into the latch.
    see_oam_ram u_oam_ram (
        .aclk    (aclk),
        .wr_en   (load_fire),
        .wr_addr (in_oam_index),
        .wr_data (in_oam_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (latch_data)
    );

    // Evaluation state machine: advance one dot per accepted tick.
    see_eval_fsm #(
        .LINE_SLOTS (LINE_SLOTS)
    ) u_eval_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .tick_valid (tick_fire),
        .dot        (in_dot),
        .scanline   (in_scanline),
        .latch_data (latch_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .result     (result)
    );

    // Result buffer: hold up to two items while the sink stalls.
    see_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (tick_fire),
        .push_data (result),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    // Pack the result item.
    assign m_tdata = {3'b000,
                      out_result.eval_done,
                      out_result.slot_count,
                      out_result.sprite_zero_found,
                      out_result.overflow_set,
                      out_result.sec_data,
                      out_result.sec_index,
                      out_result.sec_write};

`ifndef SYNTH
    a_load_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        load_fire |-> !rd_en)
        else $error("OAM read issued on a load item");

    a_read_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> tick_fire && in_dot[0])
        else $error("OAM read without an odd dot tick");

    a_tick_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_fire |=> m_tvalid)
        else $error("accepted tick left no result");
`endif

endmodule

>>> hw/rtl/see_oam_ram.sv
// Primary OAM: 256 x 8 synchronous memory, one write and one registered read port.
module see_oam_ram (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [see_pkg::OAM_ADDR_W-1:0] wr_addr,
    input  logic [7:0]                     wr_data,
    input  logic                           rd_en,
    input  logic [see_pkg::OAM_ADDR_W-1:0] rd_addr,
    output logic [7:0]                     rd_data
);
    import see_pkg::*;

    logic [7:0] mem [1 << OAM_ADDR_W];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the last read: the data register is the evaluation latch.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/see_eval_fsm.sv
// Per-dot evaluation state machine: clear, search, copy and overflow scan.
module see_eval_fsm #(
    parameter int LINE_SLOTS = see_pkg::LINE_SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  see_pkg::cfg_t                  cfg,
    input  logic                           tick_valid,
    input  logic [see_pkg::DOT_W-1:0]      dot,
    input  logic [7:0]                     scanline,
    input  logic [7:0]                     latch_data,
    output logic                           rd_en,
    output logic [see_pkg::OAM_ADDR_W-1:0] rd_addr,
    output see_pkg::result_t               result
);
    import see_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [6:0] sprite_num_reg, sprite_num_next;
    logic [1:0] byte_num_reg, byte_num_next;
    logic [5:0] write_ptr_reg, write_ptr_next;
    logic [3:0] found_count_reg, found_count_next;
    logic [1:0] extra_reads_reg, extra_reads_next;
    logic       zero_flag_reg, zero_flag_next;

    logic [8:0] dot_m1;
    logic [8:0] line_diff;
    logic [7:0] height;
    logic       on_line;
    logic [6:0] sprite_inc;
    logic [1:0] byte_inc;
    logic [3:0] found_inc;
    logic [1:0] extra_dec;

    assign dot_m1     = dot - 9'd1;
    assign height     = cfg.tall_sprites ? TALL_HEIGHT : SHORT_HEIGHT;
    assign line_diff  = {1'b0, scanline} - {1'b0, latch_data};
    assign on_line    = !line_diff[8] && (line_diff[7:0] < height);
    assign sprite_inc = sprite_num_reg + 7'd1;
    assign byte_inc   = byte_num_reg + 2'd1;
    assign found_inc  = found_count_reg + 4'd1;
    assign extra_dec  = extra_reads_reg - 2'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            sprite_num_reg  <= '0;
            byte_num_reg    <= '0;
            write_ptr_reg   <= '0;
            found_count_reg <= '0;
            extra_reads_reg <= '0;
            zero_flag_reg   <= 1'b0;
        end else if (tick_valid) begin
            phase_reg       <= phase_next;
            sprite_num_reg  <= sprite_num_next;
            byte_num_reg    <= byte_num_next;
            write_ptr_reg   <= write_ptr_next;
            found_count_reg <= found_count_next;
            extra_reads_reg <= extra_reads_next;
            zero_flag_reg   <= zero_flag_next;
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        sprite_num_next  = sprite_num_reg;
        byte_num_next    = byte_num_reg;
        write_ptr_next   = write_ptr_reg;
        found_count_next = found_count_reg;
        extra_reads_next = extra_reads_reg;
        zero_flag_next   = zero_flag_reg;
        result           = '0;
        rd_en            = 1'b0;
        rd_addr          = cfg.oam_base + {sprite_num_reg[5:0], 2'b00} + {6'd0, byte_num_reg};

        if (tick_valid && dot != 9'd0 && dot <= CLEAR_LAST_DOT) begin
            // Both dots of a pair fill the same secondary byte.
            result.sec_write = 1'b1;
            result.sec_index = dot_m1[5:1];
            result.sec_data  = FILL_BYTE;
        end else if (tick_valid && dot >= RESTART_DOT && dot <= LAST_DOT) begin
            if (dot[0]) begin
                if (dot == RESTART_DOT) begin
                    phase_next       = PH_RANGE;
                    sprite_num_next  = '0;
                    byte_num_next    = '0;
                    write_ptr_next   = '0;
                    found_count_next = '0;
                    extra_reads_next = '0;
                    zero_flag_next   = 1'b0;
                    rd_addr          = cfg.oam_base;
                end
                rd_en = 1'b1;
            end else begin
                unique case (phase_reg)
                    PH_RANGE: begin
                        result.sec_write = 1'b1;
                        result.sec_index = write_ptr_reg[4:0];
                        result.sec_data  = latch_data;
                        if (on_line) begin
                            if (sprite_num_reg == 7'd0) begin
                                zero_flag_next = 1'b1;
                            end
                            write_ptr_next = write_ptr_reg + 6'd1;
                            byte_num_next  = 2'd1;
                            phase_next     = PH_COPY;
                        end else begin
                            sprite_num_next = sprite_inc;
                            if (sprite_inc >= 7'(OAM_SPRITES)) begin
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    PH_COPY: begin
                        result.sec_write = 1'b1;
                        result.sec_index = write_ptr_reg[4:0];
                        result.sec_data  = latch_data;
                        write_ptr_next   = write_ptr_reg + 6'd1;
                        byte_num_next    = byte_inc;
                        if (byte_inc == 2'd0) begin
                            found_count_next = found_inc;
                            sprite_num_next  = sprite_inc;
                            if (sprite_inc >= 7'(OAM_SPRITES)) begin
                                phase_next = PH_IDLE;
                            end else if (found_inc >= 4'(LINE_SLOTS)) begin
                                phase_next = PH_OVF_EVAL;
                            end else begin
                                phase_next = PH_RANGE;
                            end
                        end
                    end
                    PH_OVF_EVAL: begin
                        // Advance byte_num on hit and miss alike: the skewed scan.
                        byte_num_next = byte_inc;
                        if (on_line) begin
                            result.overflow_set = 1'b1;
                            extra_reads_next    = OVF_EXTRA;
                            phase_next          = PH_OVF_COPY;
                        end else begin
                            sprite_num_next = sprite_inc;
                            if (sprite_inc >= 7'(OAM_SPRITES)) begin
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    PH_OVF_COPY: begin
                        byte_num_next    = byte_inc;
                        extra_reads_next = extra_dec;
                        if (extra_dec == 2'd0) begin
                            sprite_num_next = sprite_inc;
                            phase_next      = PH_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        result.sprite_zero_found = zero_flag_next;
        result.slot_count        = found_count_next;
        result.eval_done         = (phase_next == PH_IDLE);
    end

`ifndef SYNTH
    a_found_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        found_count_reg <= 4'(LINE_SLOTS))
        else $error("found count beyond slot count");

    a_ovf_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_OVF_EVAL || phase_reg == PH_OVF_COPY)
            |-> found_count_reg == 4'(LINE_SLOTS))
        else $error("overflow scan entered before secondary OAM full");

    a_copy_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_COPY)
            |-> write_ptr_reg == ({found_count_reg, 2'b00} + {4'd0, byte_num_reg}))
        else $error("write pointer out of step with copy byte");

    a_sprite_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        sprite_num_reg <= 7'(OAM_SPRITES))
        else $error("sprite number past end of OAM");
`endif

endmodule

>>> hw/rtl/see_out_buf.sv
// Two-entry result buffer between the evaluation logic and the result channel.
module see_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  see_pkg::result_t push_data,
    output logic             ready,
    output logic             out_valid,
    input  logic             out_ready,
    output see_pkg::result_t out_data
);
    import see_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign ready     = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && count_reg == 2'd2))
        else $error("push into full result buffer");

    a_count_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg))
        else $error("buffer count disagrees with pointers");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("buffer count beyond two entries");
`endif

endmodule

>>> tb/sv/sprite_evaluation_engine_tb.sv
// Self-checking testbench for the sprite evaluation engine: directed rows, then random scanlines.
`timescale 1ns / 1ps

module sprite_evaluation_engine_tb;
    import see_pkg::*;

    localparam int RANDOM_ITEMS = 380;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;
    localparam int RES_W        = $bits(result_t);

    // One row of the directed table; want is only used where typed is set.
    typedef struct {
        op_t        op;
        logic [7:0] idx;
        logic [7:0] val;
        logic [8:0] dot;
        logic [7:0] line;
        bit         typed;
        result_t    want;
    } dir_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_index = 1'b0;
    logic [7:0]             cfg_data  = '0;

    always #10 aclk = ~aclk;

    sprite_evaluation_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Mirror of the engine: configuration, primary OAM and search state.
    // Secondary OAM is not observable beyond the reported writes, so it
    // is not kept here.
    // ------------------------------------------------------------------
    logic       cfg_tall = 1'b0;
    logic [7:0] cfg_base = 8'h00;
    logic [7:0] oam_mirror [256];
    phase_t     ev_phase  = PH_IDLE;
    logic [6:0] ev_sprite = '0;
    logic [1:0] ev_byte   = '0;
    logic [5:0] ev_wptr   = '0;
    logic [3:0] ev_found  = '0;
    logic [1:0] ev_extra  = '0;
    logic [7:0] ev_latch  = '0;
    logic       ev_zero   = 1'b0;

    // Expected result of every accepted tick, oldest first.
    result_t eval_results_q [$];

    bit steady = 1'b0;   // when set, neither side idles
    int n_loads, n_ticks, n_cfg, n_runs, n_results, n_ovf, n_zero, mismatches;

    function automatic bit sprite_on_line(input logic [7:0] line, input logic [7:0] y);
        int height;
        height = cfg_tall ? int'(TALL_HEIGHT) : int'(SHORT_HEIGHT);
        return (line >= y) && ((int'(line) - int'(y)) < height);
    endfunction

    // Advance the mirror by one item; returns 1 when the item yields a result.
    function automatic bit eval_dot(input op_t op, input logic [7:0] idx,
                                    input logic [7:0] val, input logic [8:0] dot,
                                    input logic [7:0] line, output result_t res);
        res = '0;
        if (op == OP_LOAD) begin
            oam_mirror[idx] = val;
            return 1'b0;
        end
        if (dot >= 1 && dot <= CLEAR_LAST_DOT) begin
            // Both dots of a pair clear the same secondary byte.
            res.sec_write = 1'b1;
            res.sec_index = 5'((dot - 1) >> 1);
            res.sec_data  = FILL_BYTE;
        end else if (dot >= RESTART_DOT && dot <= LAST_DOT) begin
            if (dot == RESTART_DOT) begin
                ev_phase  = PH_RANGE;
                ev_sprite = '0;
                ev_byte   = '0;
                ev_wptr   = '0;
                ev_found  = '0;
                ev_extra  = '0;
                ev_zero   = 1'b0;
            end
            if (dot[0]) begin
                // Odd dot: latch a byte, even when idle (address is frozen then).
                ev_latch = oam_mirror[8'(cfg_base + ev_sprite[5:0] * 4 + ev_byte)];
            end else begin
                case (ev_phase)
                    PH_RANGE: begin
                        // The Y byte lands in secondary OAM whether it hits or not.
                        res.sec_write = 1'b1;
                        res.sec_index = ev_wptr[4:0];
                        res.sec_data  = ev_latch;
                        if (sprite_on_line(line, ev_latch)) begin
                            if (ev_sprite == 0) ev_zero = 1'b1;
                            ev_wptr++;
                            ev_byte  = 2'd1;
                            ev_phase = PH_COPY;
                        end else begin
                            ev_sprite++;
                            if (ev_sprite >= OAM_SPRITES) ev_phase = PH_IDLE;
                        end
                    end
                    PH_COPY: begin
                        res.sec_write = 1'b1;
                        res.sec_index = ev_wptr[4:0];
                        res.sec_data  = ev_latch;
                        ev_wptr++;
                        ev_byte++;
                        if (ev_byte == 0) begin
                            ev_found++;
                            ev_sprite++;
                            if (ev_sprite >= OAM_SPRITES)
                                ev_phase = PH_IDLE;
                            else if (ev_found >= LINE_SLOTS_DEF)
                                ev_phase = PH_OVF_EVAL;
                            else
                                ev_phase = PH_RANGE;
                        end
                    end
                    PH_OVF_EVAL: begin
                        // The byte index moves on every step, hit or miss.
                        ev_byte++;
                        if (sprite_on_line(line, ev_latch)) begin
                            res.overflow_set = 1'b1;
                            ev_extra = OVF_EXTRA;
                            ev_phase = PH_OVF_COPY;
                        end else begin
                            ev_sprite++;
                            if (ev_sprite >= OAM_SPRITES) ev_phase = PH_IDLE;
                        end
                    end
                    PH_OVF_COPY: begin
                        ev_byte++;
                        ev_extra--;
                        if (ev_extra == 0) begin
                            ev_sprite++;
                            ev_phase = PH_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
        end
        res.sprite_zero_found = ev_zero;
        res.slot_count        = ev_found;
        res.eval_done         = (ev_phase == PH_IDLE);
        return 1'b1;
    endfunction

    function automatic result_t mk_res(input bit wr, input logic [4:0] idx,
                                       input logic [7:0] data, input bit ovf,
                                       input bit zero, input logic [3:0] found,
                                       input bit done);
        result_t r;
        r.sec_write         = wr;
        r.sec_index         = idx;
        r.sec_data          = data;
        r.overflow_set      = ovf;
        r.sprite_zero_found = zero;
        r.slot_count        = found;
        r.eval_done         = done;
        return r;
    endfunction

    function automatic dir_row_t mk_row(input op_t op, input logic [7:0] idx,
                                        input logic [7:0] val, input logic [8:0] dot,
                                        input logic [7:0] line, input bit typed,
                                        input result_t want);
        dir_row_t r;
        r.op    = op;
        r.idx   = idx;
        r.val   = val;
        r.dot   = dot;
        r.line  = line;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Sender side: present one item at a falling edge, hold it until it
    // is taken, then run it through the mirror.
    // ------------------------------------------------------------------
    task automatic send_item(input op_t op, input logic [7:0] idx, input logic [7:0] val,
                             input logic [8:0] dot, input logic [7:0] line,
                             input bit typed, input result_t want);
        int gap;
        result_t res;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, line, dot, val, idx};
        do @(posedge aclk); while (!s_tready);
        if (op == OP_LOAD) n_loads++; else n_ticks++;
        if (eval_dot(op, idx, val, dot, line, res))
            eval_results_q.push_back(typed ? want : res);
    endtask

    task automatic send_load(input logic [7:0] idx, input logic [7:0] val);
        send_item(OP_LOAD, idx, val, 9'($urandom), 8'($urandom), 1'b0, '0);
    endtask

    task automatic send_tick(input logic [8:0] dot, input logic [7:0] line);
        send_item(OP_TICK, 8'($urandom), 8'($urandom), dot, line, 1'b0, '0);
    endtask

    // Drop valid, wait for every expected result, then leave room for a
    // trailing load to land before anything else touches the block.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (eval_results_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cfg(input cfg_index_t which, input logic [7:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (which == CFG_TALL_SPRITES) cfg_tall = value[0];
        else cfg_base = value;
        n_cfg++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: compare each taken item with the oldest expectation.
    // ------------------------------------------------------------------
    task automatic check_result(input logic [OUT_TDATA_W-1:0] word);
        result_t got, want;
        bit bad;
        got = word[RES_W-1:0];
        n_results++;
        if (got.overflow_set) n_ovf++;
        if (got.sprite_zero_found) n_zero++;
        if (eval_results_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result %0d: no item expected, got %h", n_results, word);
            return;
        end
        want = eval_results_q.pop_front();
        bad = (got.sec_write !== want.sec_write) || (got.sec_index !== want.sec_index) ||
              (got.sec_data !== want.sec_data) || (got.overflow_set !== want.overflow_set) ||
              (got.sprite_zero_found !== want.sprite_zero_found) ||
              (got.slot_count !== want.slot_count) ||
              (got.eval_done !== want.eval_done) || (word[OUT_TDATA_W-1:RES_W] !== '0);
        if (bad) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display({"result %0d: expected wr=%0d idx=%0d data=%h ovf=%0d zero=%0d ",
                          "found=%0d done=%0d, got wr=%0d idx=%0d data=%h ovf=%0d zero=%0d ",
                          "found=%0d done=%0d pad=%b"},
                         n_results, want.sec_write, want.sec_index, want.sec_data,
                         want.overflow_set, want.sprite_zero_found, want.slot_count,
                         want.eval_done, got.sec_write, got.sec_index, got.sec_data,
                         got.overflow_set, got.sprite_zero_found, got.slot_count,
                         got.eval_done, word[OUT_TDATA_W-1:RES_W]);
        end
    endtask

    initial begin : result_sink
        int gap;
        bit held;
        held = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = pick_gap();
            // Once, hold off long enough for the result buffer to fill and
            // back-pressure the input while the sender keeps offering.
            if (!held && n_results >= 200) begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            @(negedge aclk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            check_result(m_tdata);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, OAM fill, random scanline runs.
    // ------------------------------------------------------------------
    initial begin : stimulus
        dir_row_t   plan [$];
        int         first, last, kind, pick, start_items;
        logic [7:0] line;

        // Directed table, run at the reset configuration (8-line, base 0).
        // Clear dots, out-of-range dots and an idle even dot: no OAM read.
        plan.push_back(mk_row(OP_TICK, 8'h00, 8'h00, 9'd1,   8'd0,   1'b1,
                              mk_res(1, 5'd0,  8'hFF, 0, 0, 4'd0, 1)));
        plan.push_back(mk_row(OP_TICK, 8'hFF, 8'hFF, 9'd2,   8'd0,   1'b1,
                              mk_res(1, 5'd0,  8'hFF, 0, 0, 4'd0, 1)));
        plan.push_back(mk_row(OP_TICK, 8'h00, 8'h00, 9'd64,  8'd239, 1'b1,
                              mk_res(1, 5'd31, 8'hFF, 0, 0, 4'd0, 1)));
        plan.push_back(mk_row(OP_TICK, 8'h00, 8'h00, 9'd0,   8'd255, 1'b1,
                              mk_res(0, 5'd0,  8'h00, 0, 0, 4'd0, 1)));
        plan.push_back(mk_row(OP_TICK, 8'h00, 8'h00, 9'd511, 8'd0,   1'b1,
                              mk_res(0, 5'd0,  8'h00, 0, 0, 4'd0, 1)));
        plan.push_back(mk_row(OP_TICK, 8'h00, 8'h00, 9'd257, 8'd0,   1'b1,
                              mk_res(0, 5'd0,  8'h00, 0, 0, 4'd0, 1)));
        plan.push_back(mk_row(OP_TICK, 8'h00, 8'h00, 9'd256, 8'd0,   1'b1,
                              mk_res(0, 5'd0,  8'h00, 0, 0, 4'd0, 1)));
        // Sprite zero at Y=0 with extreme bytes, sprite one below the screen.
        plan.push_back(mk_row(OP_LOAD, 8'd0,   8'h00, 9'd0,   8'd0, 1'b0, '0));
        plan.push_back(mk_row(OP_LOAD, 8'd1,   8'hFF, 9'd511, 8'hFF, 1'b0, '0));
        plan.push_back(mk_row(OP_LOAD, 8'd2,   8'h00, 9'd0,   8'd0, 1'b0, '0));
        plan.push_back(mk_row(OP_LOAD, 8'd3,   8'hFF, 9'd0,   8'd0, 1'b0, '0));
        plan.push_back(mk_row(OP_LOAD, 8'd4,   8'hF0, 9'd0,   8'd0, 1'b0, '0));
        plan.push_back(mk_row(OP_LOAD, 8'd255, 8'hAA, 9'd0,   8'd0, 1'b0, '0));
        // Restart, hit on sprite zero, three-byte copy, then a range miss
        // that still writes its Y byte.
        for (int d = 65; d <= 74; d++)
            plan.push_back(mk_row(OP_TICK, 8'h00, 8'h00, 9'(d), 8'd0, 1'b0, '0));

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i])
            send_item(plan[i].op, plan[i].idx, plan[i].val, plan[i].dot, plan[i].line,
                      plan[i].typed, plan[i].want);

        // Pause until drained, move to the opposite extremes, then fill all
        // of primary OAM so no later read hits an unwritten byte. Y bytes
        // cluster around mid-screen so lines overflow often.
        settle();
        write_cfg(CFG_TALL_SPRITES, 8'd1);
        write_cfg(CFG_OAM_BASE, 8'hFF);
        for (int i = 0; i < 256; i++) begin
            if (i % 4 == 0 && $urandom_range(0, 9) < 7)
                send_load(8'(i), 8'($urandom_range(90, 130)));
            else
                send_load(8'(i), 8'($urandom));
        end

        start_items = n_loads + n_ticks;
        while (n_loads + n_ticks < start_items + RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                settle();
                write_cfg(CFG_TALL_SPRITES, 8'($urandom_range(0, 1)));
                pick = $urandom_range(0, 3);
                write_cfg(CFG_OAM_BASE, pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom));
            end
            steady = ($urandom_range(0, 4) == 0);
            kind   = $urandom_range(0, 9);
            line   = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(90, 140)) : 8'($urandom);
            if (kind < 8) begin
                // Well-formed run: from the clear or the restart dot, or a
                // continuation that resumes the search from its current state.
                if (kind < 6) first = $urandom_range(0, 1) ? 1 : 65;
                else first = $urandom_range(66, 250);
                last = ($urandom_range(0, 3) != 0) ? 256 : $urandom_range(first, 256);
                for (int d = first; d <= last; d++) begin
                    if ($urandom_range(0, 19) == 0) send_load(8'($urandom), 8'($urandom));
                    send_tick(9'(d), line);
                end
                n_runs++;
            end else begin
                // Noise: loads and ticks at any dot and line, in any order.
                repeat ($urandom_range(8, 24)) begin
                    if ($urandom_range(0, 1)) send_load(8'($urandom), 8'($urandom));
                    else send_tick(9'($urandom), 8'($urandom));
                end
            end
        end

        steady = 1'b0;
        settle();
        repeat (10) @(posedge aclk);
        $display("covered %0d OAM loads, %0d dot ticks in %0d scanline runs, %0d config writes",
                 n_loads, n_ticks, n_runs, n_cfg);
        $display("saw %0d overflow pulses and %0d results with sprite zero on the line",
                 n_ovf, n_zero);
        if (mismatches == 0 && eval_results_q.size() == 0) begin
            $display("sprite_evaluation_engine: match");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches,
                     eval_results_q.size());
            $display("sprite_evaluation_engine: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #(20_000_000);
        $display("timeout with %0d results outstanding", eval_results_q.size());
        $display("sprite_evaluation_engine: mismatch");
        $finish;
    end

endmodule

>>> sprite_evaluation_engine.f
hw/rtl/see_pkg.sv
hw/rtl/see_oam_ram.sv
hw/rtl/see_eval_fsm.sv
hw/rtl/see_out_buf.sv
hw/rtl/sprite_evaluation_engine.sv
tb/sv/sprite_evaluation_engine_tb.sv
